[rtl/core/ctsh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctsh_pkg
// Shared types, constants and sine table for the cloud texture shader.
// ----------------------------------------------------------------------------
package ctsh_pkg;

   localparam int SINE_TERMS      = 4;
   localparam int SINE_TABLE_BITS = 10;

   localparam int QIDX_W = SINE_TABLE_BITS - 2;
   localparam int QTAB_N = 1 << QIDX_W;

   localparam int TERM_W = 19;
   localparam int SUM_W  = TERM_W + $clog2(SINE_TERMS + 1);
   localparam int PROD_W = 2 * SUM_W;

   localparam int DIV_BPS    = 4;
   localparam int DIV_STAGES = 16 / DIV_BPS;

   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [15:0] SKY_RG      = 16'd20316;
   localparam logic [15:0] SKY_B       = 16'd51118;
   localparam longint      WEIGHT_STEP = 46334;
   localparam longint      InvDiv      = 2 * SINE_TERMS * SINE_TERMS * 16384;

   typedef enum logic [2:0] {
      CSR_THRESH   = 3'd0,
      CSR_SPAN     = 3'd1,
      CSR_CONTRAST = 3'd2,
      CSR_FREQ_U   = 3'd3,
      CSR_FREQ_V   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] u_coord;
      logic [15:0] v_coord;
   } req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [16:0] inten;
      logic        tr_full;
      logic        tr_zero;
   } div_side_type;

   typedef logic [14:0] qtab_type [QTAB_N];
   typedef logic [16:0] wtab_type [SINE_TERMS];

   // quarter-wave polynomial, Q0.15 magnitude at quarter index k
   function automatic logic [14:0] sine_mag(int k);
      longint t;
      longint t2;
      longint acc;
      longint s;
      t   = longint'(k) << (16 - SINE_TABLE_BITS);
      t2  = (t * t) / 16384;
      acc = -1256734;
      acc = 21392319 + (acc * t2) / 16384;
      acc = -173399641 + (acc * t2) / 16384;
      acc = 421657428 + (acc * t2) / 16384;
      s   = (acc * t) / 16384;
      s   = (s + 4096) / 8192;
      if (s > 32767) s = 32767;
      if (s < 0) s = 0;
      return s[14:0];
   endfunction

   function automatic qtab_type make_qtab();
      qtab_type tab;
      for (int k = 0; k < QTAB_N; k++) begin
         tab[k] = sine_mag(k);
      end
      return tab;
   endfunction

   function automatic wtab_type make_wtab();
      wtab_type tab;
      longint   w;
      w = 65536;
      for (int i = 0; i < SINE_TERMS; i++) begin
         tab[i] = w[16:0];
         w = (w * WEIGHT_STEP) >> 16;
      end
      return tab;
   endfunction

   localparam qtab_type    QSIN     = make_qtab();
   localparam logic [14:0] QSIN_TOP = sine_mag(QTAB_N);
   localparam wtab_type    WEIGHT   = make_wtab();

   // table sine of a Q16 turn phase, Q1.15
   function automatic logic signed [15:0] sine_q15(input logic [15:0] ph);
      logic [1:0]        quad;
      logic [QIDX_W-1:0] q;
      logic [QIDX_W-1:0] qm;
      logic [14:0]       mag;
      quad = ph[15:14];
      q    = ph[13 -: QIDX_W];
      qm   = QIDX_W'(0) - q;
      if (!quad[0]) mag = QSIN[q];
      else if (q == '0) mag = QSIN_TOP;
      else mag = QSIN[qm];
      return quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
   endfunction

endpackage
`default_nettype wire

[rtl/core/ctsh_octaves.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctsh_octaves
// Five-stage pipe: phases, modulation sines, term sines, weighted terms, sums.
// ----------------------------------------------------------------------------
module ctsh_octaves import ctsh_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire req_type                 in_data,
   input  wire logic [15:0]             freq_u,
   input  wire logic [15:0]             freq_v,
   input  wire logic signed [14:0]      contrast,
   output logic                         out_valid,
   output logic signed [SUM_W-1:0]      sum_u,
   output logic signed [SUM_W-1:0]      sum_v
);

   logic [4:0]               vld_ff;
   logic [31:0]              pu_ff, pv_ff;
   logic [15:0]              phu_ff [SINE_TERMS];
   logic [15:0]              phv_ff [SINE_TERMS];
   logic signed [15:0]       modu_ff [SINE_TERMS];
   logic signed [15:0]       modv_ff [SINE_TERMS];
   logic signed [15:0]       sinu_ff [SINE_TERMS];
   logic signed [15:0]       sinv_ff [SINE_TERMS];
   logic signed [TERM_W-1:0] termu_ff [SINE_TERMS];
   logic signed [TERM_W-1:0] termv_ff [SINE_TERMS];
   logic signed [SUM_W-1:0]  sumu_ff, sumv_ff;

   logic [15:0]              phu_in [SINE_TERMS];
   logic [15:0]              phv_in [SINE_TERMS];
   logic signed [15:0]       modu_in [SINE_TERMS];
   logic signed [15:0]       modv_in [SINE_TERMS];
   logic signed [15:0]       sinu_in [SINE_TERMS];
   logic signed [15:0]       sinv_in [SINE_TERMS];
   logic signed [TERM_W-1:0] termu_in [SINE_TERMS];
   logic signed [TERM_W-1:0] termv_in [SINE_TERMS];
   logic signed [SUM_W-1:0]  sumu_in, sumv_in;
   logic signed [TERM_W-1:0] c8;
   logic signed [33:0]       wpu, wpv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // octave i phase is bits [23-i:8-i] of freq*coord, half phase [24-i:9-i]
   always_comb begin
      for (int i = 0; i < SINE_TERMS; i++) begin
         phu_in[i] = pu_ff[23-i -: 16];
         phv_in[i] = pv_ff[23-i -: 16];
      end
      modu_in[0] = sine_q15(pv_ff[24:9]) / 16'sd2;
      modv_in[0] = sine_q15(pu_ff[24:9]) / 16'sd2;
      for (int i = 1; i < SINE_TERMS; i++) begin
         modu_in[i] = sine_q15(pv_ff[24-i -: 16]) / 16'sd2;
         modv_in[i] = sine_q15(pu_ff[24-i -: 16]) / 16'sd2;
      end
   end

   always_comb begin
      for (int i = 0; i < SINE_TERMS; i++) begin
         sinu_in[i] = sine_q15(phu_ff[i] + $unsigned(modu_ff[i]));
         sinv_in[i] = sine_q15(phv_ff[i] + $unsigned(modv_ff[i]));
      end
   end

   always_comb begin
      c8 = TERM_W'(contrast) <<< 3;
      for (int i = 0; i < SINE_TERMS; i++) begin
         wpu = signed'({1'b0, WEIGHT[i]}) * sinu_ff[i];
         wpv = signed'({1'b0, WEIGHT[i]}) * sinv_ff[i];
         termu_in[i] = TERM_W'(wpu / 34'sd65536) + c8;
         termv_in[i] = TERM_W'(wpv / 34'sd65536) + c8;
      end
   end

   always_comb begin
      sumu_in = '0;
      sumv_in = '0;
      for (int i = 0; i < SINE_TERMS; i++) begin
         sumu_in = sumu_in + SUM_W'(termu_ff[i]);
         sumv_in = sumv_in + SUM_W'(termv_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff    <= 32'(freq_u) * 32'(in_data.u_coord);
         pv_ff    <= 32'(freq_v) * 32'(in_data.v_coord);
         phu_ff   <= phu_in;
         phv_ff   <= phv_in;
         modu_ff  <= modu_in;
         modv_ff  <= modv_in;
         sinu_ff  <= sinu_in;
         sinv_ff  <= sinv_in;
         termu_ff <= termu_in;
         termv_ff <= termv_in;
         sumu_ff  <= sumu_in;
         sumv_ff  <= sumv_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign sum_u     = sumu_ff;
   assign sum_v     = sumv_ff;

endmodule
`default_nettype wire

[rtl/core/ctsh_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctsh_div
// Pipelined restoring fraction divider: rem/divisor with rem < divisor.
// ----------------------------------------------------------------------------
module ctsh_div import ctsh_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [15:0]  in_rem,
   input  wire div_side_type in_side,
   input  wire logic [15:0]  divisor,
   output logic              out_valid,
   output logic [15:0]       out_quot,
   output div_side_type      out_side
);

   logic [DIV_STAGES-1:0] vld_ff;
   logic [15:0]           rem_ff  [DIV_STAGES];
   logic [15:0]           quot_ff [DIV_STAGES];
   div_side_type          side_ff [DIV_STAGES];
   logic [15:0]           rem_src [DIV_STAGES];
   logic [15:0]           quot_src [DIV_STAGES];
   logic [15:0]           rem_in  [DIV_STAGES];
   logic [15:0]           quot_in [DIV_STAGES];

   always_comb begin
      rem_src[0]  = in_rem;
      quot_src[0] = '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         rem_src[s]  = rem_ff[s-1];
         quot_src[s] = quot_ff[s-1];
      end
   end

   always_comb begin
      logic [15:0] r;
      logic [16:0] r2;
      logic [15:0] q;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = rem_src[s];
         q = quot_src[s];
         for (int b = 0; b < DIV_BPS; b++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, divisor}) begin
               r = 16'(r2 - {1'b0, divisor});
               q = {q[14:0], 1'b1};
            end else begin
               r = r2[15:0];
               q = {q[14:0], 1'b0};
            end
         end
         rem_in[s]  = r;
         quot_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff     <= rem_in;
         quot_ff    <= quot_in;
         side_ff[0] <= in_side;
         for (int s = 1; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_quot  = quot_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

[rtl/core/cloud_texture_shader_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cloud_texture_shader_top
// Sum-of-sines cloud texture: (u,v) in, sky-blended RGB out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_data  (u_coord, v_coord)
//  rsp      out  rsp_valid/rsp_ready  rsp_data  (red, green, blue)
//  csr      in   csr_wr_en            csr_index, csr_wdata
//
// One request per cycle sustained while rsp is not stalled.
// Stages: 5 in the octave pipe, product, intensity, threshold, 4 divider
// stages (4 quotient bits each), blend multiply, output register.
// The whole pipe moves on one enable; a stalled rsp freezes every stage.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module cloud_texture_shader_top import ctsh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration
   logic [15:0]        thresh_ff, span_ff, freq_u_ff, freq_v_ff;
   logic signed [14:0] contrast_ff;
   logic [15:0]        span_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= 16'd22938;
         span_ff     <= 16'd19661;
         contrast_ff <= 15'sd4096;
         freq_u_ff   <= 16'd512;
         freq_v_ff   <= 16'd256;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_THRESH:   thresh_ff   <= csr_wdata;
            CSR_SPAN:     span_ff     <= csr_wdata;
            CSR_CONTRAST: contrast_ff <= signed'(csr_wdata[14:0]);
            CSR_FREQ_U:   freq_u_ff   <= csr_wdata;
            CSR_FREQ_V:   freq_v_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero span acts as one: hard step at thresh
   assign span_eff = (span_ff == '0) ? 16'd1 : span_ff;

   // global advance: output slot empty or being drained
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // octave sums
   logic                    oct_valid;
   logic signed [SUM_W-1:0] sum_u, sum_v;

   ctsh_octaves u_octaves (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .freq_u    (freq_u_ff),
      .freq_v    (freq_v_ff),
      .contrast  (contrast_ff),
      .out_valid (oct_valid),
      .sum_u     (sum_u),
      .sum_v     (sum_v)
   );

   // product, intensity, threshold classification
   localparam logic signed [PROD_W-1:0] INTEN_DIV = PROD_W'(InvDiv);

   logic                     prod_vld_ff, inten_vld_ff, thr_vld_ff;
   logic signed [PROD_W-1:0] prod_ff, iq;
   logic [16:0]              inten_ff, inten_in;
   logic signed [17:0]       diff;
   logic [15:0]              rem_ff, rem_in;
   div_side_type             side_ff, side_in;

   always_comb begin
      iq = prod_ff / INTEN_DIV;
      if (iq > PROD_W'(65536)) inten_in = ONE_Q16;
      else if (iq < 0) inten_in = '0;
      else inten_in = iq[16:0];
   end

   // diff <= 0: TR saturates at one; diff >= span: TR is zero
   always_comb begin
      diff            = signed'({1'b0, inten_ff}) - signed'({2'b0, thresh_ff});
      side_in.inten   = inten_ff;
      side_in.tr_full = (diff <= 0);
      side_in.tr_zero = (diff >= signed'({2'b0, span_eff}));
      rem_in          = (side_in.tr_full || side_in.tr_zero) ? '0 : diff[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         inten_vld_ff <= 1'b0;
         thr_vld_ff   <= 1'b0;
      end else if (en) begin
         prod_vld_ff  <= oct_valid;
         inten_vld_ff <= prod_vld_ff;
         thr_vld_ff   <= inten_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= PROD_W'(sum_u) * PROD_W'(sum_v);
         inten_ff <= inten_in;
         rem_ff   <= rem_in;
         side_ff  <= side_in;
      end
   end

   // (I - thresh) / span as a 16-bit fraction
   logic         div_valid;
   logic [15:0]  div_quot;
   div_side_type div_side;

   ctsh_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (thr_vld_ff),
      .in_rem    (rem_ff),
      .in_side   (side_ff),
      .divisor   (span_eff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // blend: (1-TR)*I + TR*sky
   logic        mul_vld_ff;
   logic [16:0] tr;
   logic [33:0] mi_ff, mrg_ff, mb_ff;
   logic [34:0] srg, sb;
   rsp_type     out_in, rsp_ff;
   logic        rsp_vld_ff;

   always_comb begin
      if (div_side.tr_full) tr = ONE_Q16;
      else if (div_side.tr_zero) tr = '0;
      else tr = ONE_Q16 - {1'b0, div_quot};
   end

   always_comb begin
      srg = 35'(mi_ff) + 35'(mrg_ff);
      sb  = 35'(mi_ff) + 35'(mb_ff);
      out_in.red   = (|srg[34:32]) ? 16'hFFFF : srg[31:16];
      out_in.green = out_in.red;
      out_in.blue  = (|sb[34:32]) ? 16'hFFFF : sb[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         mul_vld_ff <= div_valid;
         rsp_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mi_ff  <= 34'(ONE_Q16 - tr) * 34'(div_side.inten);
         mrg_ff <= 34'(tr) * 34'(SKY_RG);
         mb_ff  <= 34'(tr) * 34'(SKY_B);
         rsp_ff <= out_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // red and green share the same sky constant
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.red == rsp_data.green)
      else $error("red and green channels differ");

   // a stall freezes the divider output
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(div_valid) && $stable(div_quot))
      else $error("divider stage moved during stall");

   // reset empties the pipe
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !div_valid && !oct_valid)
      else $error("valid bits survive reset");
`endif

endmodule
`default_nettype wire
